### rtl/nmsc_pkg.sv
// Types, codes and per-position functions of the near-match string classifier.
package nmsc_pkg;

  localparam int CHAR_W  = 8;
  localparam int CLASS_W = 4;
  localparam int FLAGS_W = 4;
  localparam int STEPS_W = 2;

  localparam logic [CLASS_W-1:0] CLASS_SAME      = 4'd0;
  localparam logic [CLASS_W-1:0] CLASS_TRANSPOSE = 4'd1;
  localparam logic [CLASS_W-1:0] CLASS_ONE_DIFF  = 4'd2;
  localparam logic [CLASS_W-1:0] CLASS_MULTIPLE  = 4'd3;
  localparam logic [CLASS_W-1:0] CLASS_O_ZERO    = 4'd4;
  localparam logic [CLASS_W-1:0] CLASS_L_ONE     = 4'd5;
  localparam logic [CLASS_W-1:0] CLASS_TWO_Z     = 4'd6;
  localparam logic [CLASS_W-1:0] CLASS_FIVE_S    = 4'd7;
  localparam logic [CLASS_W-1:0] CLASS_N_H       = 4'd8;

  localparam int FLAG_TRANSPOSE = 0;
  localparam int FLAG_ALIGNED   = 1;
  localparam int FLAG_SHIFT_S   = 2;
  localparam int FLAG_SHIFT_T   = 3;
  localparam logic [FLAGS_W-1:0] FLAGS_ALL = '1;

  localparam logic [STEPS_W-1:0] STEPS_NONE = 2'd0;
  localparam logic [STEPS_W-1:0] STEPS_ONE  = 2'd1;
  localparam logic [STEPS_W-1:0] STEPS_MORE = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BIG_O  = 8'h4F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SMALL_L = 8'h6C;
  localparam logic [CHAR_W-1:0] CHAR_ONE    = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_TWO    = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_BIG_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_FIVE   = 8'h35;
  localparam logic [CHAR_W-1:0] CHAR_BIG_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_SMALL_N = 8'h6E;
  localparam logic [CHAR_W-1:0] CHAR_SMALL_H = 8'h68;

  typedef struct packed {
    logic [CHAR_W-1:0] char_first;
    logic [CHAR_W-1:0] char_second;
    logic              last_item;
  } item_t;

  typedef struct packed {
    logic               all_equal;
    logic [STEPS_W-1:0] steps;
    logic [CHAR_W-1:0]  mm_first;
    logic [CHAR_W-1:0]  mm_second;
    logic [CHAR_W-1:0]  prev_first;
    logic [CHAR_W-1:0]  prev_second;
    logic [FLAGS_W-1:0] flags;
  } track_t;

  localparam track_t TRACK_RESET = '{
    all_equal:   1'b1,
    steps:       STEPS_NONE,
    mm_first:    CHAR_NUL,
    mm_second:   CHAR_NUL,
    prev_first:  CHAR_NUL,
    prev_second: CHAR_NUL,
    flags:       FLAGS_ALL
  };

  function automatic track_t take_position(track_t s, logic [CHAR_W-1:0] x,
                                           logic [CHAR_W-1:0] y);
    track_t n;
    logic [FLAGS_W-1:0] f;
    logic swap;
    n = s;
    f = s.flags;
    swap = (x == s.mm_second) && (y == s.mm_first) && (x != CHAR_NUL) && (y != CHAR_NUL);
    if (s.all_equal) begin
      if (x != y) begin
        n.all_equal = 1'b0;
        n.mm_first  = x;
        n.mm_second = y;
        n.steps     = STEPS_ONE;
        n.flags     = FLAGS_ALL;
      end
    end else begin
      if (x != y) f[FLAG_ALIGNED] = 1'b0;
      if (x != s.prev_second) f[FLAG_SHIFT_S] = 1'b0;
      if (s.prev_first != y) f[FLAG_SHIFT_T] = 1'b0;
      if (s.steps == STEPS_ONE) begin
        if (!swap) f[FLAG_TRANSPOSE] = 1'b0;
        n.steps = STEPS_MORE;
      end else if (x != y) begin
        f[FLAG_TRANSPOSE] = 1'b0;
      end
      n.flags = f;
    end
    n.prev_first  = x;
    n.prev_second = y;
    return n;
  endfunction

  function automatic logic pair_is(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                                   logic [CHAR_W-1:0] p, logic [CHAR_W-1:0] q);
    return ((a == p) && (b == q)) || ((a == q) && (b == p));
  endfunction

  function automatic logic [CLASS_W-1:0] substitution_class(logic [CHAR_W-1:0] a,
                                                            logic [CHAR_W-1:0] b);
    logic [CLASS_W-1:0] c;
    priority if (pair_is(a, b, CHAR_BIG_O, CHAR_ZERO))      c = CLASS_O_ZERO;
    else if (pair_is(a, b, CHAR_SMALL_L, CHAR_ONE))         c = CLASS_L_ONE;
    else if (pair_is(a, b, CHAR_TWO, CHAR_BIG_Z))           c = CLASS_TWO_Z;
    else if (pair_is(a, b, CHAR_FIVE, CHAR_BIG_S))          c = CLASS_FIVE_S;
    else if (pair_is(a, b, CHAR_SMALL_N, CHAR_SMALL_H))     c = CLASS_N_H;
    else                                                    c = CLASS_ONE_DIFF;
    return c;
  endfunction

  function automatic logic [CLASS_W-1:0] classify(track_t s);
    logic a_nz;
    logic b_nz;
    logic [CLASS_W-1:0] c;
    a_nz = (s.mm_first != CHAR_NUL);
    b_nz = (s.mm_second != CHAR_NUL);
    priority if (s.all_equal)                                  c = CLASS_SAME;
    else if (a_nz && b_nz && s.flags[FLAG_TRANSPOSE])          c = CLASS_TRANSPOSE;
    else if (a_nz && b_nz && s.flags[FLAG_ALIGNED])
      c = substitution_class(s.mm_first, s.mm_second);
    else if (a_nz && s.flags[FLAG_SHIFT_S])                    c = CLASS_ONE_DIFF;
    else if (b_nz && s.flags[FLAG_SHIFT_T])                    c = CLASS_ONE_DIFF;
    else                                                       c = CLASS_MULTIPLE;
    return c;
  endfunction

endpackage

### rtl/nmsc_in_if.sv
// Request channel carrying one character pair per item.
interface nmsc_in_if
  import nmsc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_first;
  logic [CHAR_W-1:0] char_second;
  logic              last_item;

  modport source (output valid, char_first, char_second, last_item, input ready);
  modport sink   (input valid, char_first, char_second, last_item, output ready);
endinterface

### rtl/nmsc_out_if.sv
// Result channel carrying one match class per string, sent after its last request.
interface nmsc_out_if
  import nmsc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] match_class;

  modport source (output valid, match_class, input ready);
  modport sink   (input valid, match_class, output ready);
endinterface

### rtl/nmsc_input_stage.sv
// Input register stage holding one accepted character pair.
module nmsc_input_stage
  import nmsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  nmsc_in_if.sink  items,
  input  logic     advance,
  output item_t    item,
  output logic     item_valid
);

  logic  valid;
  item_t data;

  assign items.ready = !valid || advance;
  assign item        = data;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (items.ready) begin
      valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      data.char_first  <= items.char_first;
      data.char_second <= items.char_second;
      data.last_item   <= items.last_item;
    end
  end

endmodule

### rtl/nmsc_tracker.sv
// Running mismatch tracker, final classification and result register.
module nmsc_tracker
  import nmsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       item_valid,
  output logic       advance,
  nmsc_out_if.source results
);

  track_t             track;
  track_t             track_next;
  track_t             track_final;
  logic               res_valid;
  logic [CLASS_W-1:0] res_class;
  logic               take;

  assign advance     = !item.last_item || !res_valid || results.ready;
  assign take        = item_valid && advance;
  assign track_next  = take_position(track, item.char_first, item.char_second);
  assign track_final = take_position(track_next, CHAR_NUL, CHAR_NUL);

  assign results.valid       = res_valid;
  assign results.match_class = res_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      track <= TRACK_RESET;
    end else if (take) begin
      track <= item.last_item ? TRACK_RESET : track_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && item.last_item) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_item) begin
      res_class <= classify(track_final);
    end
  end

endmodule

### rtl/near_match_string_classifier_core.sv
// Top level of the near-match string classifier.
//
//   channel   direction  payload                              handshake
//   items     in         char_first, char_second, last_item   valid/ready
//   results   out        match_class                          valid/ready
//
// One request per cycle unless a last request waits on a stalled result; a last request
// passes the input register, then the tracker and result register, before its class leaves.
// rst clears the tracker and both valid bits.
// A stalled result blocks a following last request and the requests behind it; earlier ones keep flowing.
module near_match_string_classifier_core
  import nmsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  nmsc_in_if.sink    items,
  nmsc_out_if.source results
);

  item_t item;
  logic  item_valid;
  logic  advance;

  nmsc_input_stage u_input_stage (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  nmsc_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .advance    (advance),
    .results    (results)
  );

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(item_valid && item.last_item && advance))
    else $error("result appeared without a last request");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.last_item && advance) |=> results.valid)
    else $error("last request produced no result");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.match_class <= CLASS_N_H))
    else $error("match class out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |-> (item.last_item && results.valid && !results.ready))
    else $error("input stage stalled without a pending result");

endmodule
